// File: src/rsqd_pkg.sv
package rsqd_pkg;

  // Number of Newton-Raphson refinements applied to the interpolated seed.
  localparam int NEWTON_STEPS = 2;

  localparam logic KIND_RSQRT = 1'b0;
  localparam logic KIND_DIST  = 1'b1;

  localparam logic [31:0] RSQRT_OF_ZERO = 32'hFFFF_FFFF;
  localparam logic [31:0] RSQRT_OF_ONE  = 32'd65536;
  localparam logic [31:0] THREE_Q16     = 32'h0003_0000;

  // Side data that rides along with an operand through the pipeline.
  typedef struct packed {
    logic        kind;
    logic        reduced;
    logic        is_zero;
    logic        is_one;
    logic [47:0] sq_sum;
  } side_t;

  // Position of the highest set bit; 0 for an operand of 0 or 1.
  function automatic logic [4:0] top_bit(input logic [31:0] v);
    logic [4:0] e;
    e = 5'd0;
    for (int k = 1; k < 32; k++) begin
      if (v[k]) begin
        e = 5'(k);
      end
    end
    return e;
  endfunction

  // Seed table, roughly 65536 * 2^(-e/2).
  function automatic logic [15:0] seed_rom(input logic [4:0] idx);
    logic [15:0] r;
    case (idx)
      5'd0:  r = 16'd65535;
      5'd1:  r = 16'd46341;
      5'd2:  r = 16'd32768;
      5'd3:  r = 16'd23170;
      5'd4:  r = 16'd16384;
      5'd5:  r = 16'd11585;
      5'd6:  r = 16'd8192;
      5'd7:  r = 16'd5793;
      5'd8:  r = 16'd4096;
      5'd9:  r = 16'd2896;
      5'd10: r = 16'd2048;
      5'd11: r = 16'd1448;
      5'd12: r = 16'd1024;
      5'd13: r = 16'd724;
      5'd14: r = 16'd512;
      5'd15: r = 16'd362;
      5'd16: r = 16'd256;
      5'd17: r = 16'd181;
      5'd18: r = 16'd128;
      5'd19: r = 16'd90;
      5'd20: r = 16'd64;
      5'd21: r = 16'd45;
      5'd22: r = 16'd32;
      5'd23: r = 16'd23;
      5'd24: r = 16'd16;
      5'd25: r = 16'd11;
      5'd26: r = 16'd8;
      5'd27: r = 16'd6;
      5'd28: r = 16'd4;
      5'd29: r = 16'd3;
      5'd30: r = 16'd2;
      5'd31: r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/rsqd_front.sv
// Operand front end: squares, sum of squares, range reduction, operand select.
module rsqd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [31:0]         value,
  input  logic signed [31:0]  delta_x,
  input  logic signed [31:0]  delta_y,
  input  logic signed [31:0]  delta_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         op,
  output rsqd_pkg::side_t     side
);

  logic        vld1, vld2;
  logic        rdy1, rdy2;
  logic        kind1;
  logic [31:0] value1;
  logic [63:0] sqx, sqy, sqz;
  logic [63:0] sum;
  logic        big;

  assign rdy2     = !vld2 || out_ready;
  assign rdy1     = !vld1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      if (rdy1) vld1 <= in_valid;
      if (rdy2) vld2 <= vld1;
    end
  end

  // stage 1: three exact 64-bit squares
  always_ff @(posedge clk) begin
    if (rdy1) begin
      kind1  <= kind;
      value1 <= value;
      sqx    <= delta_x * delta_x;
      sqy    <= delta_y * delta_y;
      sqz    <= delta_z * delta_z;
    end
  end

  // stage 2: sum fits in 64 bits; above 32 bits it is scaled down by 2^16
  assign sum = sqx + sqy + sqz;
  assign big = (sum[63:32] != 32'd0);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      side.kind    <= kind1;
      side.is_zero <= 1'b0;
      side.is_one  <= 1'b0;
      if (kind1 == rsqd_pkg::KIND_DIST) begin
        side.reduced <= big;
        side.sq_sum  <= big ? sum[63:16] : sum[47:0];
        op           <= big ? sum[47:16] : sum[31:0];
      end else begin
        side.reduced <= 1'b0;
        side.sq_sum  <= 48'd0;
        op           <= value1;
      end
    end
  end

  assign out_valid = vld2;

endmodule

// File: src/rsqd_seed.sv
// Seed lookup with linear interpolation between adjacent table entries.
module rsqd_seed (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     op_in,
  input  rsqd_pkg::side_t side_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     y_out,
  output logic [31:0]     op_out,
  output rsqd_pkg::side_t side_out
);

  logic            vld1, vld2, vld3;
  logic            rdy1, rdy2, rdy3;
  logic [4:0]      e1;
  logic [15:0]     frac1;
  logic [31:0]     op1, op2;
  rsqd_pkg::side_t side1, side2;
  rsqd_pkg::side_t side_c;
  logic [4:0]      e_in;
  logic [47:0]     shifted;
  logic [15:0]     y0_c, nxt_c, span_c;
  logic [15:0]     y0_2;
  logic [31:0]     prod2;

  assign rdy3     = !vld3 || out_ready;
  assign rdy2     = !vld2 || rdy3;
  assign rdy1     = !vld1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (rdy1) vld1 <= in_valid;
      if (rdy2) vld2 <= vld1;
      if (rdy3) vld3 <= vld2;
    end
  end

  // stage 1: exponent and 16-bit fraction of the mantissa below the top bit
  assign e_in    = rsqd_pkg::top_bit(op_in);
  assign shifted = {op_in, 16'h0000} >> e_in;

  // special operands are flagged here, where the root operand is final
  always_comb begin
    side_c         = side_in;
    side_c.is_zero = (op_in == 32'd0);
    side_c.is_one  = (op_in == 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      e1    <= e_in;
      frac1 <= shifted[15:0];
      op1   <= op_in;
      side1 <= side_c;
    end
  end

  // stage 2: table reads and interpolation product
  assign y0_c   = rsqd_pkg::seed_rom(e1);
  assign nxt_c  = (e1 == 5'd31) ? 16'd0 : rsqd_pkg::seed_rom(e1 + 5'd1);
  assign span_c = y0_c - nxt_c;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      y0_2  <= y0_c;
      prod2 <= span_c * frac1;
      op2   <= op1;
      side2 <= side1;
    end
  end

  // stage 3: interpolated seed
  always_ff @(posedge clk) begin
    if (rdy3) begin
      y_out    <= {16'h0000, y0_2 - prod2[31:16]};
      op_out   <= op2;
      side_out <= side2;
    end
  end

  assign out_valid = vld3;

endmodule

// File: src/rsqd_newton.sv
// One Newton-Raphson step: y = y * (3 - v*y^2) / 2, in Q16.16, over three stages.
module rsqd_newton (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     y_in,
  input  logic [31:0]     op_in,
  input  rsqd_pkg::side_t side_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     y_out,
  output logic [31:0]     op_out,
  output rsqd_pkg::side_t side_out
);

  logic            vld1, vld2, vld3;
  logic            rdy1, rdy2, rdy3;
  logic [31:0]     y1, y2, sq1, corr2, op1, op2;
  rsqd_pkg::side_t side1, side2;
  logic [63:0]     sq_full, vsq_full, y_full;

  assign rdy3     = !vld3 || out_ready;
  assign rdy2     = !vld2 || rdy3;
  assign rdy1     = !vld1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (rdy1) vld1 <= in_valid;
      if (rdy2) vld2 <= vld1;
      if (rdy3) vld3 <= vld2;
    end
  end

  assign sq_full  = y_in * y_in;
  assign vsq_full = op1 * sq1;
  assign y_full   = y2 * corr2;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sq1   <= sq_full[31:0];
      y1    <= y_in;
      op1   <= op_in;
      side1 <= side_in;
    end
    if (rdy2) begin
      corr2 <= rsqd_pkg::THREE_Q16 - vsq_full[47:16];
      y2    <= y1;
      op2   <= op1;
      side2 <= side1;
    end
    if (rdy3) begin
      y_out    <= y_full[48:17];
      op_out   <= op2;
      side_out <= side2;
    end
  end

  assign out_valid = vld3;

endmodule

// File: src/rsqd_final.sv
// Special operands, distance product and result formatting.
module rsqd_final (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     y_in,
  input  rsqd_pkg::side_t side_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     answer,
  output logic            range_reduced
);

  logic            vld1, vld2;
  logic            rdy1, rdy2;
  logic [31:0]     inv_c, inv1;
  logic [63:0]     plo1;
  logic [31:0]     phi1;
  logic [47:0]     prod;
  rsqd_pkg::side_t side1;

  assign rdy2     = !vld2 || out_ready;
  assign rdy1     = !vld1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      if (rdy1) vld1 <= in_valid;
      if (rdy2) vld2 <= vld1;
    end
  end

  always_comb begin
    if (side_in.is_zero) begin
      inv_c = rsqd_pkg::RSQRT_OF_ZERO;
    end else if (side_in.is_one) begin
      inv_c = rsqd_pkg::RSQRT_OF_ONE;
    end else begin
      inv_c = y_in;
    end
  end

  // only the low 48 bits of sum * inv reach the answer
  always_ff @(posedge clk) begin
    if (rdy1) begin
      inv1  <= inv_c;
      plo1  <= side_in.sq_sum[31:0] * inv_c;
      phi1  <= side_in.sq_sum[47:32] * inv_c[15:0];
      side1 <= side_in;
    end
  end

  assign prod = plo1[47:0] + {phi1[15:0], 32'h0000_0000};

  always_ff @(posedge clk) begin
    if (rdy2) begin
      range_reduced <= side1.reduced;
      if (side1.kind == rsqd_pkg::KIND_RSQRT) begin
        answer <= inv1;
      end else if (side1.reduced) begin
        answer <= {prod[39:16], 8'h00};
      end else begin
        answer <= prod[47:16];
      end
    end
  end

  assign out_valid = vld2;

endmodule

// File: src/fixed_point_rsqrt_and_distance.sv
// Fixed-point reciprocal square root and 3-D distance unit.
//
// Input channel (in_valid/in_ready): kind 0 takes the unsigned operand on
// value and returns its Q16.16 reciprocal square root; kind 1 takes the
// signed deltas and returns the integer length of (dx, dy, dz). Unused
// fields are ignored.
// Output channel (out_valid/ready): answer plus range_reduced, which is set
// when the squared length needed more than 32 bits and was scaled by 2^-16
// (the answer is then scaled back up by 2^8, low 8 bits zero).
//
// Pipeline: 13 register stages: 2 front end, 3 seed lookup/interpolation,
// 3 per Newton step (2 steps), 2 final.
// Throughput: one transfer per cycle while ready stays high. Front end stage 1
// holds three multiplies and final stage 1 two; other stages at most one.
// Each stage has its own valid bit and advances when it is empty or its
// successor advances, so a stalled receiver backs the pipe up one stage at
// a time; bubbles are squeezed out and input is taken until all stages fill.
// Reset (rst, synchronous) clears all valid bits; no results are pending.
module fixed_point_rsqrt_and_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [31:0]        value,
  input  logic signed [31:0] delta_x,
  input  logic signed [31:0] delta_y,
  input  logic signed [31:0] delta_z,
  output logic               out_valid,
  input  logic               ready,
  output logic [31:0]        answer,
  output logic               range_reduced
);

  localparam int NS = rsqd_pkg::NEWTON_STEPS;

  // front end -> seed
  logic            fr_valid, fr_ready;
  logic [31:0]     fr_op;
  rsqd_pkg::side_t fr_side;

  // Newton chain: index 0 is the seed output, index NS the refined root
  logic            nt_valid [NS+1];
  logic            nt_ready [NS+1];
  logic [31:0]     nt_y     [NS+1];
  logic [31:0]     nt_op    [NS+1];
  rsqd_pkg::side_t nt_side  [NS+1];

  rsqd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value     (value),
    .delta_x   (delta_x),
    .delta_y   (delta_y),
    .delta_z   (delta_z),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .op        (fr_op),
    .side      (fr_side)
  );

  rsqd_seed u_seed (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .op_in     (fr_op),
    .side_in   (fr_side),
    .out_valid (nt_valid[0]),
    .out_ready (nt_ready[0]),
    .y_out     (nt_y[0]),
    .op_out    (nt_op[0]),
    .side_out  (nt_side[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_newton
    rsqd_newton u_newton (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (nt_valid[i]),
      .in_ready  (nt_ready[i]),
      .y_in      (nt_y[i]),
      .op_in     (nt_op[i]),
      .side_in   (nt_side[i]),
      .out_valid (nt_valid[i+1]),
      .out_ready (nt_ready[i+1]),
      .y_out     (nt_y[i+1]),
      .op_out    (nt_op[i+1]),
      .side_out  (nt_side[i+1])
    );
  end

  // the operand is no longer needed once the root is refined
  rsqd_final u_final (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (nt_valid[NS]),
    .in_ready      (nt_ready[NS]),
    .y_in          (nt_y[NS]),
    .side_in       (nt_side[NS]),
    .out_valid     (out_valid),
    .out_ready     (ready),
    .answer        (answer),
    .range_reduced (range_reduced)
  );

  logic unused_op;
  assign unused_op = ^nt_op[NS];

endmodule

// File: src/rsqd_checker.sv
module rsqd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        ready,
  input logic [31:0] answer,
  input logic        range_reduced
);

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ready |=> out_valid && $stable(answer) && $stable(range_reduced))
    else $error("output changed while stalled");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // with the last stage empty every stage is free to move
  a_take: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input blocked with an empty output stage");

  // a rescaled distance is always a multiple of 256
  a_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_reduced |-> answer[7:0] == 8'h00)
    else $error("reduced result not rescaled");

endmodule

bind fixed_point_rsqrt_and_distance rsqd_checker u_rsqd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .ready         (ready),
  .answer        (answer),
  .range_reduced (range_reduced)
);
